>>> hdl/vms_pkg.sv
// Shared types, codes and reset constants for the valve motor sequencer.
// No dependencies; every other file in hdl/ imports this package.
package vms_pkg;

   // default width of the start-delay and stall timers
   localparam int TIMER_WIDTH_DEF = 16;

   // field widths fixed by the interface
   localparam int DELAY_W  = 16;
   localparam int STALL_W  = 16;
   localparam int SETTLE_W = 8;
   localparam int BLINK_W  = 3;

   // configuration port
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_STALL_LIMIT  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SETTLE_TICKS = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BLINK_PERIOD = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_OUTAGE_OPEN  = 8'd3;

   localparam logic [STALL_W-1:0]  STALL_LIMIT_RST  = 16'd400;
   localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RST = 8'd20;
   localparam logic [BLINK_W-1:0]  BLINK_PERIOD_RST = 3'd4;
   localparam logic                OUTAGE_OPEN_RST  = 1'b1;

   // sequence phase
   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_READY  = 2'd1,
      PH_ACTIVE = 2'd2,
      PH_FINISH = 2'd3
   } phase_type;

   // demand codes
   localparam logic [1:0] DEM_NONE   = 2'd0;
   localparam logic [1:0] DEM_OPEN   = 2'd1;
   localparam logic [1:0] DEM_CLOSED = 2'd2;

   // motor commands
   localparam logic [1:0] CMD_HOLD  = 2'd0;
   localparam logic [1:0] CMD_OPEN  = 2'd1;
   localparam logic [1:0] CMD_CLOSE = 2'd2;
   localparam logic [1:0] CMD_STOP  = 2'd3;

   // valve position
   localparam logic [1:0] POS_UNKNOWN = 2'd0;
   localparam logic [1:0] POS_OPEN    = 2'd1;
   localparam logic [1:0] POS_CLOSED  = 2'd2;

   // stall codes
   localparam logic [1:0] STALL_NONE    = 2'd0;
   localparam logic [1:0] STALL_OPENING = 2'd1;
   localparam logic [1:0] STALL_CLOSING = 2'd2;

   // LED modes
   localparam logic [1:0] LED_OPEN_BLINK   = 2'd0;
   localparam logic [1:0] LED_CLOSE_BLINK  = 2'd1;
   localparam logic [1:0] LED_OPEN_STEADY  = 2'd2;
   localparam logic [1:0] LED_CLOSE_STEADY = 2'd3;

   // LED register bits
   localparam logic [1:0] LED_BIT_OPEN  = 2'b01;
   localparam logic [1:0] LED_BIT_CLOSE = 2'b10;

   typedef struct packed {
      logic [STALL_W-1:0]  stall_limit;
      logic [SETTLE_W-1:0] settle_ticks;
      logic [BLINK_W-1:0]  blink_period;
      logic                outage_open_enable;
   } cfg_type;

   typedef struct packed {
      logic               trigger;
      logic [DELAY_W-1:0] open_delay_load;
      logic [DELAY_W-1:0] close_delay_load;
      logic [1:0]         demand;
      logic               mains_present;
      logic               motor_at_open;
      logic               motor_at_closed;
      logic               led_test_mode;
   } req_item_type;

   typedef struct packed {
      logic [1:0] motor_cmd;
      logic [1:0] valve_position;
      logic [1:0] stall_code;
      logic       valve_fault;
      logic       valve_error_latched;
      logic       open_led;
      logic       close_led;
      logic       record_pulse;
      logic [1:0] phase;
   } rsp_item_type;

endpackage

>>> hdl/valve_motor_sequencer.sv
// Top level of the valve motor sequencer: input stage, result stage, CSR block.
// Depends on vms_pkg, vms_csr and vms_core.
//
// Each input word on req_* is one tick of the sequencer; each tick gives exactly
// one result word on rsp_*. Both channels move a word at a clock edge where
// valid is high and stall is low; the receiver drives stall.
// A word accepted on req_* sits in the input stage; the core computes its result
// combinationally, and the result is registered into the result stage when the
// word moves on, which rsp_stall can hold off; rsp_valid comes from that stage.
// While rsp_stall is low, one word is accepted every cycle, throughput one
// word per cycle, set by the combinational core update between the two stages.
// When rsp_stall is held, the result stage holds its word, the next word waits
// in the input stage and req_stall rises only once both stages are full.
// Configuration writes on csr_* are never held off (csr_ready is always high);
// they must be made only while no words are in flight; the block does not check.
// Synchronous reset returns the sequence to idle, clears timers, faults and
// LEDs, sets the position to unknown and reloads the register defaults.
module valve_motor_sequencer #(
   parameter int TIMER_WIDTH = vms_pkg::TIMER_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_trigger,
   input  logic [vms_pkg::DELAY_W-1:0]     req_open_delay_load,
   input  logic [vms_pkg::DELAY_W-1:0]     req_close_delay_load,
   input  logic [1:0]                      req_demand,
   input  logic                            req_mains_present,
   input  logic                            req_motor_at_open,
   input  logic                            req_motor_at_closed,
   input  logic                            req_led_test_mode,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_motor_cmd,
   output logic [1:0]                      rsp_valve_position,
   output logic [1:0]                      rsp_stall_code,
   output logic                            rsp_valve_fault,
   output logic                            rsp_valve_error_latched,
   output logic                            rsp_open_led,
   output logic                            rsp_close_led,
   output logic                            rsp_record_pulse,
   output logic [1:0]                      rsp_phase,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [vms_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [vms_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import vms_pkg::*;

   cfg_type      cfg;
   req_item_type in_item_ff, in_item_in;
   rsp_item_type out_item_ff, step_result;
   logic         in_vld_ff, in_vld_in;
   logic         out_vld_ff, out_vld_in;
   logic         req_take;
   logic         move;

   // handshake: a word moves on when the result stage is free or draining
   assign move      = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !move;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // capture the incoming word
   always_comb begin
      in_item_in.trigger          = req_trigger;
      in_item_in.open_delay_load  = req_open_delay_load;
      in_item_in.close_delay_load = req_close_delay_load;
      in_item_in.demand           = req_demand;
      in_item_in.mains_present    = req_mains_present;
      in_item_in.motor_at_open    = req_motor_at_open;
      in_item_in.motor_at_closed  = req_motor_at_closed;
      in_item_in.led_test_mode    = req_led_test_mode;
   end

   // stage occupancy
   always_comb begin
      in_vld_in  = req_take ? 1'b1 : (move ? 1'b0 : in_vld_ff);
      out_vld_in = move ? 1'b1 : (rsp_stall ? out_vld_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) in_item_ff <= in_item_in;
      if (move) out_item_ff <= step_result;
   end

   vms_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   vms_core #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (move),
      .cfg     (cfg),
      .item    (in_item_ff),
      .result  (step_result)
   );

   assign rsp_valid               = out_vld_ff;
   assign rsp_motor_cmd           = out_item_ff.motor_cmd;
   assign rsp_valve_position      = out_item_ff.valve_position;
   assign rsp_stall_code          = out_item_ff.stall_code;
   assign rsp_valve_fault         = out_item_ff.valve_fault;
   assign rsp_valve_error_latched = out_item_ff.valve_error_latched;
   assign rsp_open_led            = out_item_ff.open_led;
   assign rsp_close_led           = out_item_ff.close_led;
   assign rsp_record_pulse        = out_item_ff.record_pulse;
   assign rsp_phase               = out_item_ff.phase;

   // a held input word is never dropped
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !move) |=> in_vld_ff)
      else $error("input word lost while waiting");

   // a word handed to the result stage shows up there
   a_move_lands: assert property (@(posedge clock) disable iff (reset)
      move |=> out_vld_ff)
      else $error("result word missing after move");

   // a record pulse comes only with a run or stop command
   a_record_drive: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_item_ff.record_pulse) |-> (out_item_ff.motor_cmd != CMD_HOLD))
      else $error("record pulse without motor drive");

endmodule

>>> hdl/vms_csr.sv
// Configuration registers of the valve motor sequencer.
// Depends on vms_pkg for register indexes, reset values and cfg_type.
module vms_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [vms_pkg::CSR_INDEX_W-1:0]  wr_index,
   input  logic [vms_pkg::CSR_DATA_W-1:0]   wr_data,
   output vms_pkg::cfg_type                 cfg
);
   import vms_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // decode the write word into its register
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            REG_STALL_LIMIT:  cfg_in.stall_limit        = wr_data[STALL_W-1:0];
            REG_SETTLE_TICKS: cfg_in.settle_ticks       = wr_data[SETTLE_W-1:0];
            REG_BLINK_PERIOD: cfg_in.blink_period       = wr_data[BLINK_W-1:0];
            REG_OUTAGE_OPEN:  cfg_in.outage_open_enable = wr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stall_limit        <= STALL_LIMIT_RST;
         cfg_ff.settle_ticks       <= SETTLE_TICKS_RST;
         cfg_ff.blink_period       <= BLINK_PERIOD_RST;
         cfg_ff.outage_open_enable <= OUTAGE_OPEN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/vms_core.sv
// Sequencer state and the one-tick update: phase, timers, position, faults, LEDs.
// Depends on vms_pkg; the state advances once per word moved to the result stage.
module vms_core #(
   parameter int TIMER_WIDTH = vms_pkg::TIMER_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  vms_pkg::cfg_type      cfg,
   input  vms_pkg::req_item_type item,
   output vms_pkg::rsp_item_type result
);
   import vms_pkg::*;

   localparam int CMP_W = (TIMER_WIDTH > STALL_W) ? TIMER_WIDTH : STALL_W;

   phase_type             phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0] cnt_a_ff, cnt_a_in;
   logic [TIMER_WIDTH-1:0] cnt_b_ff, cnt_b_in;
   logic [TIMER_WIDTH-1:0] stall_cnt_ff, stall_cnt_in;
   logic [SETTLE_W-1:0]    open_settle_ff, open_settle_in;
   logic [SETTLE_W-1:0]    close_settle_ff, close_settle_in;
   logic [1:0]             pos_ff, pos_in;
   logic [1:0]             stall_code_ff, stall_code_in;
   logic                   err_ff, err_in;
   logic                   fault_ff, fault_in;
   logic [1:0]             led_mode_ff, led_mode_in;
   logic [BLINK_W-1:0]     blink_cnt_ff, blink_cnt_in;
   logic                   blink_ph_ff, blink_ph_in;
   logic [1:0]             led_ff, led_in;

   logic [1:0] cmd;
   logic       rec;
   logic       done;
   logic       active;

   assign active = !item.trigger && (phase_ff == PH_ACTIVE);

   // one tick of counters, motor drive, position and LED state
   always_comb begin
      logic                   opening;
      logic                   end_seen;
      logic [TIMER_WIDTH-1:0] stall_inc;
      logic [SETTLE_W-1:0]    settle_inc;
      logic [1:0]             self_bit;
      logic [1:0]             other_bit;

      cnt_a_in        = cnt_a_ff;
      cnt_b_in        = cnt_b_ff;
      stall_cnt_in    = stall_cnt_ff;
      open_settle_in  = open_settle_ff;
      close_settle_in = close_settle_ff;
      pos_in          = pos_ff;
      stall_code_in   = stall_code_ff;
      err_in          = err_ff;
      fault_in        = fault_ff;
      led_mode_in     = led_mode_ff;
      blink_cnt_in    = blink_cnt_ff;
      blink_ph_in     = blink_ph_ff;
      led_in          = led_ff;
      cmd             = CMD_HOLD;
      rec             = 1'b0;
      done            = 1'b0;
      opening         = (item.demand == DEM_OPEN);
      end_seen        = opening ? item.motor_at_open : item.motor_at_closed;
      stall_inc       = stall_cnt_ff + 1'b1;
      settle_inc      = (opening ? open_settle_ff : close_settle_ff) + 1'b1;
      self_bit        = LED_BIT_OPEN;
      other_bit       = LED_BIT_CLOSE;

      // load or count down the start delays
      if (item.trigger) begin
         cnt_a_in = TIMER_WIDTH'(item.open_delay_load);
         cnt_b_in = TIMER_WIDTH'(item.close_delay_load);
      end else if (phase_ff == PH_READY) begin
         if (cnt_a_ff != '0) cnt_a_in = cnt_a_ff - 1'b1;
         if (cnt_b_ff != '0) cnt_b_in = cnt_b_ff - 1'b1;
      end

      if (active) begin
         if (stall_code_ff != STALL_NONE) err_in = 1'b1;

         // drive toward the demanded end, time the move
         if (item.mains_present) begin
            if (item.demand == DEM_OPEN || item.demand == DEM_CLOSED) begin
               stall_cnt_in = stall_inc;
               if (CMP_W'(stall_inc) >= CMP_W'(cfg.stall_limit)) begin
                  stall_cnt_in  = '0;
                  stall_code_in = opening ? STALL_OPENING : STALL_CLOSING;
                  fault_in      = 1'b1;
               end
               cmd = opening ? CMD_OPEN : CMD_CLOSE;
               if (end_seen) begin
                  pos_in        = opening ? POS_OPEN : POS_CLOSED;
                  stall_cnt_in  = '0;
                  stall_code_in = STALL_NONE;
                  fault_in      = 1'b0;
                  rec           = 1'b1;
                  if (settle_inc >= cfg.settle_ticks) begin
                     settle_inc = '0;
                     cmd        = CMD_STOP;
                     done       = 1'b1;
                  end
                  if (opening) open_settle_in = settle_inc;
                  else close_settle_in = settle_inc;
               end
            end
         end else if (cfg.outage_open_enable) begin
            cmd = CMD_OPEN;
            if (item.motor_at_open) begin
               pos_in = POS_OPEN;
               cmd    = CMD_STOP;
               done   = 1'b1;
            end
         end

         // pick the LED mode from position and demand
         priority if (pos_in == POS_OPEN && item.demand == DEM_CLOSED)
            led_mode_in = LED_CLOSE_BLINK;
         else if (pos_in == POS_CLOSED && item.demand == DEM_OPEN)
            led_mode_in = LED_OPEN_BLINK;
         else if (pos_in == POS_OPEN && item.demand == DEM_OPEN)
            led_mode_in = LED_OPEN_STEADY;
         else if (pos_in == POS_CLOSED && item.demand == DEM_CLOSED)
            led_mode_in = LED_CLOSE_STEADY;
         else
            led_mode_in = led_mode_ff;

         // refresh the LEDs unless under test
         if (!item.led_test_mode) begin
            unique case (led_mode_in)
               LED_OPEN_BLINK, LED_CLOSE_BLINK: begin
                  if (led_mode_in == LED_CLOSE_BLINK) begin
                     self_bit  = LED_BIT_CLOSE;
                     other_bit = LED_BIT_OPEN;
                  end
                  led_in       = led_ff & ~other_bit;
                  blink_cnt_in = blink_cnt_ff + 1'b1;
                  if (blink_cnt_in == BLINK_W'(1)) begin
                     if (!blink_ph_ff) begin
                        led_in      = led_in & ~self_bit;
                        blink_ph_in = 1'b1;
                     end else begin
                        led_in      = led_in | self_bit;
                        blink_ph_in = 1'b0;
                     end
                  end else if (blink_cnt_in >= cfg.blink_period) begin
                     blink_cnt_in = '0;
                  end
               end
               LED_OPEN_STEADY:  led_in = LED_BIT_OPEN;
               LED_CLOSE_STEADY: led_in = LED_BIT_CLOSE;
               default: ;
            endcase
         end
      end

      // on mains loss show the known position steady
      if (!item.mains_present) begin
         if (pos_in == POS_OPEN) led_mode_in = LED_OPEN_STEADY;
         else if (pos_in == POS_CLOSED) led_mode_in = LED_CLOSE_STEADY;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (item.trigger) begin
         phase_in = PH_READY;
      end else begin
         unique case (phase_ff)
            PH_IDLE: ;
            PH_READY: if (cnt_a_in == '0 && cnt_b_in == '0) phase_in = PH_ACTIVE;
            PH_ACTIVE: if (done) phase_in = PH_FINISH;
            PH_FINISH: phase_in = PH_IDLE;
            default: ;
         endcase
      end
   end

   // result word of this tick
   always_comb begin
      result.motor_cmd           = cmd;
      result.valve_position      = pos_in;
      result.stall_code          = stall_code_in;
      result.valve_fault         = fault_in;
      result.valve_error_latched = err_in;
      result.open_led            = led_in[0];
      result.close_led           = led_in[1];
      result.record_pulse        = rec;
      result.phase               = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         cnt_a_ff        <= '0;
         cnt_b_ff        <= '0;
         stall_cnt_ff    <= '0;
         open_settle_ff  <= '0;
         close_settle_ff <= '0;
         pos_ff          <= POS_UNKNOWN;
         stall_code_ff   <= STALL_NONE;
         err_ff          <= 1'b0;
         fault_ff        <= 1'b0;
         led_mode_ff     <= LED_OPEN_BLINK;
         blink_cnt_ff    <= '0;
         blink_ph_ff     <= 1'b0;
         led_ff          <= '0;
      end else if (step_en) begin
         phase_ff        <= phase_in;
         cnt_a_ff        <= cnt_a_in;
         cnt_b_ff        <= cnt_b_in;
         stall_cnt_ff    <= stall_cnt_in;
         open_settle_ff  <= open_settle_in;
         close_settle_ff <= close_settle_in;
         pos_ff          <= pos_in;
         stall_code_ff   <= stall_code_in;
         err_ff          <= err_in;
         fault_ff        <= fault_in;
         led_mode_ff     <= led_mode_in;
         blink_cnt_ff    <= blink_cnt_in;
         blink_ph_ff     <= blink_ph_in;
         led_ff          <= led_in;
      end
   end

   // fault and stall code move together
   a_fault_tracks_stall: assert property (@(posedge clock) disable iff (reset)
      fault_ff == (stall_code_ff != STALL_NONE))
      else $error("fault flag out of step with stall code");

   // the error latch never drops once set
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      err_ff |=> err_ff)
      else $error("error latch cleared");

   // a finished sequence stopped the motor on that tick
   a_finish_stops: assert property (@(posedge clock) disable iff (reset)
      (step_en && phase_in == PH_FINISH) |-> (cmd == CMD_STOP))
      else $error("finish phase entered without stop command");

endmodule

>>> bench/vms_checker.sv
// Checker for the valve motor sequencer: watches the tick, result and CSR channels.
// Keeps its own copy of the sequencer state and settings and compares every result word.
// Depends on vms_pkg; instantiated beside the block by tb_valve_motor_sequencer.
module vms_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_trigger,
   input  logic [vms_pkg::DELAY_W-1:0]     req_open_delay_load,
   input  logic [vms_pkg::DELAY_W-1:0]     req_close_delay_load,
   input  logic [1:0]                      req_demand,
   input  logic                            req_mains_present,
   input  logic                            req_motor_at_open,
   input  logic                            req_motor_at_closed,
   input  logic                            req_led_test_mode,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [1:0]                      rsp_motor_cmd,
   input  logic [1:0]                      rsp_valve_position,
   input  logic [1:0]                      rsp_stall_code,
   input  logic                            rsp_valve_fault,
   input  logic                            rsp_valve_error_latched,
   input  logic                            rsp_open_led,
   input  logic                            rsp_close_led,
   input  logic                            rsp_record_pulse,
   input  logic [1:0]                      rsp_phase,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [vms_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [vms_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              fail_count,
   output int                              results_due
);
   import vms_pkg::*;

   // settings as last written on the CSR port
   cfg_type cfg;

   // sequencer state mirror
   phase_type          ph;
   logic [DELAY_W-1:0] dly_a, dly_b;
   logic [STALL_W-1:0] drive_ticks;
   logic [SETTLE_W-1:0] open_settle, close_settle;
   logic [1:0]         pos, stall_code, led_mode, leds;
   logic               err, fault, blink_ph;
   logic [BLINK_W-1:0] blink_cnt;

   // result words still owed by the block, oldest first
   rsp_item_type tick_results_due[$];

   // advance the blink pattern of one LED and switch the other one off
   function automatic void blink_led(input logic [1:0] own_bit, input logic [1:0] other_bit);
      leds = leds & ~other_bit;
      blink_cnt = blink_cnt + 1'b1;
      if (blink_cnt == 1) begin
         if (!blink_ph) begin
            leds = leds & ~own_bit;
            blink_ph = 1'b1;
         end else begin
            leds = leds | own_bit;
            blink_ph = 1'b0;
         end
      end else if (blink_cnt >= cfg.blink_period) begin
         blink_cnt = '0;
      end
   endfunction

   // run one tick of the sequencer and return the result word it gives
   function automatic rsp_item_type sequencer_tick(input req_item_type w);
      rsp_item_type r;
      logic         opening, at_end, settled;
      r = '0;
      r.motor_cmd = CMD_HOLD;
      if (w.trigger) begin
         // trigger wins in every phase: load delays, no countdown this tick
         dly_a = w.open_delay_load;
         dly_b = w.close_delay_load;
         ph = PH_READY;
      end else begin
         case (ph)
            PH_READY: begin
               if (dly_a != 0) dly_a = dly_a - 1'b1;
               if (dly_b != 0) dly_b = dly_b - 1'b1;
               if (dly_a == 0 && dly_b == 0) ph = PH_ACTIVE;
            end
            PH_ACTIVE: begin
               if (stall_code != STALL_NONE) err = 1'b1;
               if (w.mains_present) begin
                  if (w.demand == DEM_OPEN || w.demand == DEM_CLOSED) begin
                     opening = (w.demand == DEM_OPEN);
                     drive_ticks = drive_ticks + 1'b1;
                     if (drive_ticks >= cfg.stall_limit) begin
                        drive_ticks = '0;
                        stall_code = opening ? STALL_OPENING : STALL_CLOSING;
                        fault = 1'b1;
                     end
                     r.motor_cmd = opening ? CMD_OPEN : CMD_CLOSE;
                     at_end = opening ? w.motor_at_open : w.motor_at_closed;
                     if (at_end) begin
                        pos = opening ? POS_OPEN : POS_CLOSED;
                        drive_ticks = '0;
                        stall_code = STALL_NONE;
                        fault = 1'b0;
                        r.record_pulse = 1'b1;
                        // each direction keeps its own settle count
                        if (opening) begin
                           open_settle = open_settle + 1'b1;
                           settled = (open_settle >= cfg.settle_ticks);
                           if (settled) open_settle = '0;
                        end else begin
                           close_settle = close_settle + 1'b1;
                           settled = (close_settle >= cfg.settle_ticks);
                           if (settled) close_settle = '0;
                        end
                        if (settled) begin
                           r.motor_cmd = CMD_STOP;
                           ph = PH_FINISH;
                        end
                     end
                  end
               end else if (cfg.outage_open_enable) begin
                  // outage path: open without stall timing, stop on the open switch
                  r.motor_cmd = CMD_OPEN;
                  if (w.motor_at_open) begin
                     pos = POS_OPEN;
                     r.motor_cmd = CMD_STOP;
                     ph = PH_FINISH;
                  end
               end
               if (pos == POS_OPEN && w.demand == DEM_CLOSED) led_mode = LED_CLOSE_BLINK;
               else if (pos == POS_CLOSED && w.demand == DEM_OPEN) led_mode = LED_OPEN_BLINK;
               else if (pos == POS_OPEN && w.demand == DEM_OPEN) led_mode = LED_OPEN_STEADY;
               else if (pos == POS_CLOSED && w.demand == DEM_CLOSED) led_mode = LED_CLOSE_STEADY;
               if (!w.led_test_mode) begin
                  case (led_mode)
                     LED_OPEN_BLINK:  blink_led(LED_BIT_OPEN, LED_BIT_CLOSE);
                     LED_CLOSE_BLINK: blink_led(LED_BIT_CLOSE, LED_BIT_OPEN);
                     LED_OPEN_STEADY: leds = LED_BIT_OPEN;
                     default:         leds = LED_BIT_CLOSE;
                  endcase
               end
            end
            PH_FINISH: ph = PH_IDLE;
            default: ;
         endcase
      end
      // on mains loss a known position forces the steady LED mode every tick
      if (!w.mains_present) begin
         if (pos == POS_OPEN) led_mode = LED_OPEN_STEADY;
         else if (pos == POS_CLOSED) led_mode = LED_CLOSE_STEADY;
      end
      r.valve_position      = pos;
      r.stall_code          = stall_code;
      r.valve_fault         = fault;
      r.valve_error_latched = err;
      r.open_led            = leds[0];
      r.close_led           = leds[1];
      r.phase               = ph;
      return r;
   endfunction

   task automatic check_field(input string field, input logic [1:0] want, input logic [1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      req_item_type w;
      rsp_item_type want;
      if (reset) begin
         // reload defaults and clear the sequence
         cfg.stall_limit        = STALL_LIMIT_RST;
         cfg.settle_ticks       = SETTLE_TICKS_RST;
         cfg.blink_period       = BLINK_PERIOD_RST;
         cfg.outage_open_enable = OUTAGE_OPEN_RST;
         ph = PH_IDLE;
         dly_a = '0;
         dly_b = '0;
         drive_ticks = '0;
         open_settle = '0;
         close_settle = '0;
         pos = POS_UNKNOWN;
         stall_code = STALL_NONE;
         err = 1'b0;
         fault = 1'b0;
         led_mode = LED_OPEN_BLINK;
         blink_cnt = '0;
         blink_ph = 1'b0;
         leds = '0;
         tick_results_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_STALL_LIMIT:  cfg.stall_limit = csr_wdata[STALL_W-1:0];
               REG_SETTLE_TICKS: cfg.settle_ticks = csr_wdata[SETTLE_W-1:0];
               REG_BLINK_PERIOD: cfg.blink_period = csr_wdata[BLINK_W-1:0];
               REG_OUTAGE_OPEN:  cfg.outage_open_enable = csr_wdata[0];
               default: ;
            endcase
         end
         // retire the oldest expectation before queueing a new one
         if (rsp_valid && !rsp_stall) begin
            if (tick_results_due.size() == 0) begin
               $display("%0t: result word with no expectation waiting", $time);
               fail_count++;
            end else begin
               want = tick_results_due.pop_front();
               check_field("motor_cmd", want.motor_cmd, rsp_motor_cmd);
               check_field("valve_position", want.valve_position, rsp_valve_position);
               check_field("stall_code", want.stall_code, rsp_stall_code);
               check_field("valve_fault", want.valve_fault, rsp_valve_fault);
               check_field("valve_error_latched", want.valve_error_latched,
                           rsp_valve_error_latched);
               check_field("open_led", want.open_led, rsp_open_led);
               check_field("close_led", want.close_led, rsp_close_led);
               check_field("record_pulse", want.record_pulse, rsp_record_pulse);
               check_field("phase", want.phase, rsp_phase);
            end
         end
         if (req_valid && !req_stall) begin
            w.trigger          = req_trigger;
            w.open_delay_load  = req_open_delay_load;
            w.close_delay_load = req_close_delay_load;
            w.demand           = req_demand;
            w.mains_present    = req_mains_present;
            w.motor_at_open    = req_motor_at_open;
            w.motor_at_closed  = req_motor_at_closed;
            w.led_test_mode    = req_led_test_mode;
            tick_results_due.push_back(sequencer_tick(w));
         end
      end
      results_due <= tick_results_due.size();
   end

endmodule

>>> bench/tb_valve_motor_sequencer.sv
// Testbench top for the valve motor sequencer: clock, reset, tick and CSR stimulus, verdict.
// Depends on vms_pkg, valve_motor_sequencer and vms_checker, which does all result checking.
module tb_valve_motor_sequencer;
   import vms_pkg::*;

   // demand code outside the defined set, must hold the motor
   localparam logic [1:0] DEM_UNDEFINED = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_trigger = 1'b0;
   logic [DELAY_W-1:0]     req_open_delay_load = '0;
   logic [DELAY_W-1:0]     req_close_delay_load = '0;
   logic [1:0]             req_demand = DEM_NONE;
   logic                   req_mains_present = 1'b1;
   logic                   req_motor_at_open = 1'b0;
   logic                   req_motor_at_closed = 1'b0;
   logic                   req_led_test_mode = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [1:0]             rsp_motor_cmd, rsp_valve_position, rsp_stall_code, rsp_phase;
   logic                   rsp_valve_fault, rsp_valve_error_latched;
   logic                   rsp_open_led, rsp_close_led, rsp_record_pulse;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = REG_STALL_LIMIT;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int      fail_count;
   int      results_due;
   int      send_quiet = 0;
   int      recv_quiet = 0;
   int      words_sent = 0;
   cfg_type cur_cfg;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   valve_motor_sequencer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_trigger(req_trigger),
      .req_open_delay_load(req_open_delay_load),
      .req_close_delay_load(req_close_delay_load),
      .req_demand(req_demand), .req_mains_present(req_mains_present),
      .req_motor_at_open(req_motor_at_open), .req_motor_at_closed(req_motor_at_closed),
      .req_led_test_mode(req_led_test_mode),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_motor_cmd(rsp_motor_cmd), .rsp_valve_position(rsp_valve_position),
      .rsp_stall_code(rsp_stall_code), .rsp_valve_fault(rsp_valve_fault),
      .rsp_valve_error_latched(rsp_valve_error_latched),
      .rsp_open_led(rsp_open_led), .rsp_close_led(rsp_close_led),
      .rsp_record_pulse(rsp_record_pulse), .rsp_phase(rsp_phase),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   vms_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_trigger(req_trigger),
      .req_open_delay_load(req_open_delay_load),
      .req_close_delay_load(req_close_delay_load),
      .req_demand(req_demand), .req_mains_present(req_mains_present),
      .req_motor_at_open(req_motor_at_open), .req_motor_at_closed(req_motor_at_closed),
      .req_led_test_mode(req_led_test_mode),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_motor_cmd(rsp_motor_cmd), .rsp_valve_position(rsp_valve_position),
      .rsp_stall_code(rsp_stall_code), .rsp_valve_fault(rsp_valve_fault),
      .rsp_valve_error_latched(rsp_valve_error_latched),
      .rsp_open_led(rsp_open_led), .rsp_close_led(rsp_close_led),
      .rsp_record_pulse(rsp_record_pulse), .rsp_phase(rsp_phase),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .results_due(results_due)
   );

   // hard stop if the run hangs
   initial begin
      #1_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // idle cycles before the next word: mostly random, with runs of back-to-back words
   function automatic int draw_wait(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         quiet_left = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 18);
   endfunction

   function automatic req_item_type make_word(input logic trig, input logic [DELAY_W-1:0] a,
                                              input logic [DELAY_W-1:0] b,
                                              input logic [1:0] dem, input logic mains,
                                              input logic at_open, input logic at_closed,
                                              input logic test);
      req_item_type w;
      w.trigger          = trig;
      w.open_delay_load  = a;
      w.close_delay_load = b;
      w.demand           = dem;
      w.mains_present    = mains;
      w.motor_at_open    = at_open;
      w.motor_at_closed  = at_closed;
      w.led_test_mode    = test;
      return w;
   endfunction

   // present one tick word after a random gap and hold it until accepted
   task automatic send_word(input req_item_type w);
      int gap;
      gap = draw_wait(send_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_trigger          <= w.trigger;
      req_open_delay_load  <= w.open_delay_load;
      req_close_delay_load <= w.close_delay_load;
      req_demand           <= w.demand;
      req_mains_present    <= w.mains_present;
      req_motor_at_open    <= w.motor_at_open;
      req_motor_at_closed  <= w.motor_at_closed;
      req_led_test_mode    <= w.led_test_mode;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // drop valid and wait until every result word is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
   endtask

   // write all four registers back to back, then drop valid once
   task automatic write_settings(input cfg_type c);
      csr_valid <= 1'b1;
      csr_index <= REG_STALL_LIMIT;
      csr_wdata <= c.stall_limit;
      do @(posedge clock); while (!csr_ready);
      csr_index <= REG_SETTLE_TICKS;
      csr_wdata <= {{(CSR_DATA_W-SETTLE_W){1'b0}}, c.settle_ticks};
      do @(posedge clock); while (!csr_ready);
      csr_index <= REG_BLINK_PERIOD;
      csr_wdata <= {{(CSR_DATA_W-BLINK_W){1'b0}}, c.blink_period};
      do @(posedge clock); while (!csr_ready);
      csr_index <= REG_OUTAGE_OPEN;
      csr_wdata <= {{(CSR_DATA_W-1){1'b0}}, c.outage_open_enable};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_cfg = c;
   endtask

   // one well-formed sequence: trigger, countdown, drive to the end switch, finish
   task automatic run_sequence();
      logic [1:0] dem;
      logic       outage, hit, test;
      int         a, b, n, hint, reach, hold, len;
      if ($urandom_range(0, 9) == 0) dem = DEM_NONE;
      else dem = $urandom_range(0, 1) ? DEM_OPEN : DEM_CLOSED;
      outage = ($urandom_range(0, 7) == 0);
      a = $urandom_range(0, 4);
      b = $urandom_range(0, 4);
      if ($urandom_range(0, 15) == 0) a = $urandom_range(0, 40);
      send_word(make_word(1'b1, DELAY_W'(a), DELAY_W'(b), dem, !outage,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1))));
      n = (a > b) ? a : b;
      if (n == 0) n = 1;
      repeat (n) begin
         send_word(make_word(1'b0, '0, '0, dem, !outage, $urandom_range(0, 9) == 0,
                             $urandom_range(0, 9) == 0, 1'b0));
      end
      // end switch closes after a random reach, sometimes past the stall limit
      hint = (cur_cfg.stall_limit > 24) ? 24 : cur_cfg.stall_limit + 3;
      reach = $urandom_range(0, hint);
      hold = (cur_cfg.settle_ticks == 0) ? 1 : cur_cfg.settle_ticks;
      len = reach + hold + 1;
      if (len > 60) len = 60;
      for (int k = 0; k < len; k++) begin
         hit = (k >= reach);
         test = ($urandom_range(0, 7) == 0);
         if (outage) begin
            send_word(make_word(1'b0, '0, '0, dem, 1'b0, hit, $urandom_range(0, 7) == 0,
                                test));
         end else begin
            send_word(make_word(1'b0, '0, '0, dem, $urandom_range(0, 31) != 0,
                                (dem == DEM_OPEN) ? hit : ($urandom_range(0, 9) == 0),
                                (dem == DEM_CLOSED) ? hit : ($urandom_range(0, 9) == 0),
                                test));
         end
      end
      // let finish fall back to idle
      repeat (2) begin
         send_word(make_word(1'b0, '0, '0, 2'($urandom_range(0, 2)),
                             $urandom_range(0, 3) != 0,
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0));
      end
   endtask

   // one setting: mostly sequences, some words with every field random
   task automatic random_phase(input cfg_type c, input int budget);
      int start;
      drain();
      write_settings(c);
      start = words_sent;
      while (words_sent - start < budget) begin
         if ($urandom_range(0, 6) == 0) begin
            send_word(make_word($urandom_range(0, 3) == 0, DELAY_W'($urandom_range(0, 65535)),
                                DELAY_W'($urandom_range(0, 65535)),
                                2'($urandom_range(0, 2)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
         end else begin
            run_sequence();
         end
      end
   endtask

   // result side: stall for a random count, then take one word
   initial begin
      int n;
      wait (!reset);
      forever begin
         n = draw_wait(recv_quiet);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      cfg_type c;
      cur_cfg = '{STALL_LIMIT_RST, SETTLE_TICKS_RST, BLINK_PERIOD_RST, OUTAGE_OPEN_RST};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed, reset settings: extreme delays, retrigger, hold codes, outage open
      send_word(make_word(1'b1, 16'hFFFF, 16'hFFFF, DEM_OPEN, 1'b1, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b0, '0, '0, DEM_OPEN, 1'b1, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b1, '0, '0, DEM_OPEN, 1'b1, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b0, '0, '0, DEM_OPEN, 1'b1, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b0, '0, '0, DEM_NONE, 1'b1, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b0, '0, '0, DEM_UNDEFINED, 1'b1, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b0, '0, '0, DEM_CLOSED, 1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b0, '0, '0, DEM_CLOSED, 1'b0, 1'b1, 1'b0, 1'b0));
      send_word(make_word(1'b0, '0, '0, DEM_NONE, 1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b0, '0, '0, DEM_CLOSED, 1'b1, 1'b1, 1'b1, 1'b1));
      // uneven delays count down on their own
      send_word(make_word(1'b1, 16'd2, 16'd0, DEM_CLOSED, 1'b1, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b0, '0, '0, DEM_CLOSED, 1'b1, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b0, '0, '0, DEM_CLOSED, 1'b1, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b0, '0, '0, DEM_CLOSED, 1'b1, 1'b0, 1'b0, 1'b1));
      send_word(make_word(1'b0, '0, '0, DEM_CLOSED, 1'b1, 1'b0, 1'b1, 1'b0));
      send_word(make_word(1'b0, '0, '0, DEM_OPEN, 1'b1, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b0, '0, '0, DEM_OPEN, 1'b1, 1'b1, 1'b0, 1'b0));

      // directed, low extremes: stall on first tick, error latch, outage disabled
      drain();
      c = '{16'd1, 8'd1, 3'd1, 1'b0};
      write_settings(c);
      send_word(make_word(1'b1, '0, '0, DEM_CLOSED, 1'b1, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b0, '0, '0, DEM_CLOSED, 1'b1, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b0, '0, '0, DEM_CLOSED, 1'b1, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b0, '0, '0, DEM_CLOSED, 1'b1, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b0, '0, '0, DEM_CLOSED, 1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(1'b0, '0, '0, DEM_CLOSED, 1'b1, 1'b0, 1'b1, 1'b0));
      send_word(make_word(1'b0, '0, '0, DEM_CLOSED, 1'b1, 1'b0, 1'b0, 1'b0));

      // random part across extreme, zero and random settings
      random_phase('{16'd1, 8'd1, 3'd1, 1'b0}, 55);
      random_phase('{16'hFFFF, 8'd255, 3'd7, 1'b1}, 55);
      random_phase('{16'd0, 8'd0, 3'd0, 1'b1}, 55);
      repeat (5) begin
         c.stall_limit        = STALL_W'($urandom_range(2, 30));
         c.settle_ticks       = SETTLE_W'($urandom_range(1, 6));
         c.blink_period       = BLINK_W'($urandom_range(1, 7));
         c.outage_open_enable = 1'($urandom_range(0, 1));
         random_phase(c, 55);
      end

      drain();
      repeat (6) @(posedge clock);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> valve_motor_sequencer.f
hdl/vms_pkg.sv
hdl/vms_csr.sv
hdl/vms_core.sv
hdl/valve_motor_sequencer.sv
bench/vms_checker.sv
bench/tb_valve_motor_sequencer.sv
